// File: hdl/alarm_tone_pattern_sequencer_macros.svh
// Assertion macros used by the alarm tone sequencer checker
`ifndef ALARM_TONE_PATTERN_SEQUENCER_MACROS_SVH
`define ALARM_TONE_PATTERN_SEQUENCER_MACROS_SVH

// same-cycle implication, disabled during reset
`define ATPS_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("atps assertion failed");

// next-cycle implication, disabled during reset
`define ATPS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("atps assertion failed");

`endif

// File: hdl/atps_pkg.sv
// Types, tone ROM tables and command codes for the alarm tone sequencer
`default_nettype none

package atps_pkg;

   localparam int unsigned NUM_PATTERNS = 5;
   localparam int unsigned ROM_STEPS    = 20;
   localparam int unsigned ROM_IDX_W    = 5;
   localparam int unsigned HZ_W         = 11;
   localparam int unsigned MS_W         = 10;
   localparam int unsigned STEP_W       = 4;
   localparam int unsigned PAT_W        = 3;
   localparam int unsigned TIMER_W      = 16;

   localparam logic [MS_W-1:0] ELAPSED_MAX = 10'd1023;

   typedef enum logic [1:0] {
      CMD_TICK      = 2'd0,
      CMD_SET_ALARM = 2'd1,
      CMD_STOP      = 2'd2
   } command_type;

   localparam logic [HZ_W-1:0] TONE_HZ [ROM_STEPS] = '{
      11'd0,
      11'd880,  11'd0,
      11'd660,  11'd0,   11'd660,  11'd0,
      11'd1400, 11'd0,
      11'd800,  11'd880,  11'd960,  11'd1040, 11'd1120,
      11'd1200, 11'd1280, 11'd1360, 11'd1440, 11'd1520,
      11'd1600
   };

   localparam logic [MS_W-1:0] TONE_MS [ROM_STEPS] = '{
      10'd1000,
      10'd200, 10'd800,
      10'd150, 10'd100, 10'd150, 10'd700,
      10'd100, 10'd100,
      10'd45, 10'd45, 10'd45, 10'd45, 10'd45,
      10'd45, 10'd45, 10'd45, 10'd45, 10'd45,
      10'd45
   };

   localparam logic [ROM_IDX_W-1:0] PAT_BASE [NUM_PATTERNS] = '{
      5'd0, 5'd1, 5'd3, 5'd7, 5'd9
   };

   localparam logic [STEP_W-1:0] PAT_LEN [NUM_PATTERNS] = '{
      4'd1, 4'd2, 4'd4, 4'd2, 4'd11
   };

   typedef struct packed {
      logic               tone_on;
      logic [TIMER_W-1:0] reload;
      logic [TIMER_W-1:0] compare;
      logic [MS_W-1:0]    duration;
      logic               last;
   } step_info_type;

   typedef struct packed {
      logic               tone_on;
      logic [TIMER_W-1:0] reload_value;
      logic [TIMER_W-1:0] compare_value;
      logic [STEP_W-1:0]  step_number;
      logic [PAT_W-1:0]   pattern_number;
      logic               timer_written;
   } result_type;

endpackage

`default_nettype wire

// File: hdl/atps_chan_if.sv
// Request and response channel interfaces of the alarm tone sequencer
`default_nettype none

interface atps_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] command;
   logic [2:0] alarm_level;

   modport source (output valid, command, alarm_level, input ready);
   modport sink   (input valid, command, alarm_level, output ready);
endinterface

interface atps_rsp_if;
   logic        valid;
   logic        ready;
   logic        tone_on;
   logic [15:0] reload_value;
   logic [15:0] compare_value;
   logic [3:0]  step_number;
   logic [2:0]  pattern_number;
   logic        timer_written;

   modport source (output valid, tone_on, reload_value, compare_value, step_number,
                   pattern_number, timer_written, input ready);
   modport sink   (input valid, tone_on, reload_value, compare_value, step_number,
                   pattern_number, timer_written, output ready);
endinterface

`default_nettype wire

// File: hdl/atps_rom.sv
// Tone step ROM with elaboration-time timer reload and compare tables
`default_nettype none

module atps_rom #(
   parameter int unsigned TIMER_CLOCK_HZ = 1000000
) (
   input  wire logic [atps_pkg::PAT_W-1:0]  pattern,
   input  wire logic [atps_pkg::STEP_W-1:0] step,
   output atps_pkg::step_info_type          info
);

   logic [atps_pkg::TIMER_W-1:0] reload_tab  [atps_pkg::ROM_STEPS];
   logic [atps_pkg::TIMER_W-1:0] compare_tab [atps_pkg::ROM_STEPS];

   for (genvar i = 0; i < atps_pkg::ROM_STEPS; i++) begin : g_tab
      if (atps_pkg::TONE_HZ[i] != 0) begin : g_tone
         localparam int unsigned Period = TIMER_CLOCK_HZ / atps_pkg::TONE_HZ[i];
         localparam int unsigned Arr    = (Period == 0) ? 0 : Period - 1;
         localparam int unsigned ArrSat = (Arr > 65535) ? 65535 : Arr;
         assign reload_tab[i]  = 16'(ArrSat);
         assign compare_tab[i] = 16'((ArrSat + 1) / 2);
      end else begin : g_silent
         assign reload_tab[i]  = '0;
         assign compare_tab[i] = '0;
      end
   end

   logic [2:0]                     pat_idx;
   logic [atps_pkg::STEP_W-1:0]    pat_len;
   logic [atps_pkg::STEP_W-1:0]    step_sel;
   logic [atps_pkg::ROM_IDX_W-1:0] rom_idx;

   always_comb begin
      pat_idx  = (pattern inside {[0:4]}) ? pattern : 3'd0;
      pat_len  = atps_pkg::PAT_LEN[pat_idx];
      step_sel = (step < pat_len) ? step : '0;
      rom_idx  = atps_pkg::PAT_BASE[pat_idx] + 5'(step_sel);

      info.tone_on  = (atps_pkg::TONE_HZ[rom_idx] != '0);
      info.reload   = reload_tab[rom_idx];
      info.compare  = compare_tab[rom_idx];
      info.duration = atps_pkg::TONE_MS[rom_idx];
      info.last     = (step_sel == pat_len - 4'd1);
   end

endmodule

`default_nettype wire

// File: hdl/atps_seq.sv
// Sequencer state and next-step logic for one item per cycle while advance is high
`default_nettype none

module atps_seq #(
   parameter int unsigned TIMER_CLOCK_HZ = 1000000
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic [1:0]                  command,
   input  wire logic [2:0]                  alarm_level,
   output atps_pkg::result_type             result
);

   logic [atps_pkg::PAT_W-1:0]   pattern_ff, pattern_in;
   logic [atps_pkg::STEP_W-1:0]  step_ff, step_in;
   logic [atps_pkg::MS_W-1:0]    elapsed_ff, elapsed_in;
   logic [atps_pkg::TIMER_W-1:0] reload_ff, reload_in;
   logic [atps_pkg::TIMER_W-1:0] compare_ff, compare_in;

   atps_pkg::step_info_type cur_info, nxt_info;
   logic [atps_pkg::MS_W-1:0]  elapsed_inc;
   logic [atps_pkg::PAT_W-1:0] new_pattern;
   logic                       load, silence;

   atps_rom #(.TIMER_CLOCK_HZ(TIMER_CLOCK_HZ)) u_rom_cur (
      .pattern (pattern_ff),
      .step    (step_ff),
      .info    (cur_info)
   );

   atps_rom #(.TIMER_CLOCK_HZ(TIMER_CLOCK_HZ)) u_rom_nxt (
      .pattern (pattern_in),
      .step    (step_in),
      .info    (nxt_info)
   );

   always_comb begin
      elapsed_inc = (elapsed_ff == atps_pkg::ELAPSED_MAX) ? elapsed_ff : elapsed_ff + 10'd1;
      new_pattern = (alarm_level inside {[0:4]}) ? alarm_level : 3'd0;
      pattern_in  = pattern_ff;
      step_in     = step_ff;
      elapsed_in  = elapsed_ff;
      load        = 1'b0;
      silence     = 1'b0;
      case (command)
         atps_pkg::CMD_TICK: begin
            elapsed_in = elapsed_inc;
            if (elapsed_inc >= cur_info.duration) begin
               step_in    = cur_info.last ? '0 : step_ff + 4'd1;
               elapsed_in = '0;
               load       = 1'b1;
            end
         end
         atps_pkg::CMD_SET_ALARM: begin
            if (new_pattern != pattern_ff) begin
               pattern_in = new_pattern;
               step_in    = '0;
               elapsed_in = '0;
               load       = 1'b1;
            end
         end
         atps_pkg::CMD_STOP: begin
            pattern_in = '0;
            step_in    = '0;
            silence    = 1'b1;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      reload_in  = (load && nxt_info.tone_on) ? nxt_info.reload : reload_ff;
      compare_in = silence ? '0 : (load ? nxt_info.compare : compare_ff);

      result.tone_on        = nxt_info.tone_on;
      result.reload_value   = reload_in;
      result.compare_value  = compare_in;
      result.step_number    = step_in;
      result.pattern_number = pattern_in;
      result.timer_written  = load | silence;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pattern_ff <= '0;
         step_ff    <= '0;
         elapsed_ff <= '0;
         reload_ff  <= '0;
         compare_ff <= '0;
      end else if (advance) begin
         pattern_ff <= pattern_in;
         step_ff    <= step_in;
         elapsed_ff <= elapsed_in;
         reload_ff  <= reload_in;
         compare_ff <= compare_in;
      end
   end

endmodule

`default_nettype wire

// File: hdl/alarm_tone_pattern_sequencer.sv
// Top level of the alarm tone pattern sequencer
//
//   channel    dir  handshake      item
//   req_chan   in   valid/ready    command, alarm_level
//   rsp_chan   out  valid/ready    tone_on, reload_value, compare_value,
//                                  step_number, pattern_number, timer_written
//
// One item per cycle sustained while rsp_chan is ready; each item waits in the
// input register and moves into the result register when advance is high.
// The rate is set by the single step update between the two registers.
// Synchronous reset selects the silent pattern at step 0, timer values zero.
// A stalled result holds while one further item waits in the input register.
`default_nettype none

module alarm_tone_pattern_sequencer #(
   parameter int unsigned TIMER_CLOCK_HZ = 1000000
) (
   input wire logic   clock,
   input wire logic   reset,
   atps_req_if.sink   req_chan,
   atps_rsp_if.source rsp_chan
);

   logic       in_valid_ff, in_valid_in;
   logic [1:0] command_ff;
   logic [2:0] alarm_level_ff;
   logic       out_valid_ff, out_valid_in;
   logic       advance, req_take;

   atps_pkg::result_type result, result_ff;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !in_valid_ff || advance;
   assign req_take       = req_chan.valid && req_chan.ready;

   always_comb begin
      in_valid_in  = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_valid_in = advance ? 1'b1 : (rsp_chan.ready ? 1'b0 : out_valid_ff);
   end

   atps_seq #(.TIMER_CLOCK_HZ(TIMER_CLOCK_HZ)) u_seq (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .command     (command_ff),
      .alarm_level (alarm_level_ff),
      .result      (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         command_ff     <= req_chan.command;
         alarm_level_ff <= req_chan.alarm_level;
      end
      if (advance) begin
         result_ff <= result;
      end
   end

   assign rsp_chan.valid          = out_valid_ff;
   assign rsp_chan.tone_on        = result_ff.tone_on;
   assign rsp_chan.reload_value   = result_ff.reload_value;
   assign rsp_chan.compare_value  = result_ff.compare_value;
   assign rsp_chan.step_number    = result_ff.step_number;
   assign rsp_chan.pattern_number = result_ff.pattern_number;
   assign rsp_chan.timer_written  = result_ff.timer_written;

endmodule

`default_nettype wire

// File: hdl/atps_check.sv
// Port-level assertion checker for the alarm tone sequencer, with its bind
`default_nettype none
`include "alarm_tone_pattern_sequencer_macros.svh"

module atps_check (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic        tone_on,
   input wire logic [15:0] reload_value,
   input wire logic [15:0] compare_value,
   input wire logic [3:0]  step_number,
   input wire logic [2:0]  pattern_number
);

   logic [16:0] half_period;

   assign half_period = ({1'b0, reload_value} + 17'd1) >> 1;

   `ATPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(reload_value) && $stable(compare_value))
   `ATPS_ASSERT_NOW(a_silent_cmp, clock, reset, rsp_valid && !tone_on, compare_value == 16'd0)
   `ATPS_ASSERT_NOW(a_tone_duty, clock, reset, rsp_valid && tone_on, {1'b0, compare_value} == half_period)
   `ATPS_ASSERT_NOW(a_nominal_idle, clock, reset, rsp_valid && pattern_number == 3'd0, step_number == 4'd0 && !tone_on)

endmodule

bind alarm_tone_pattern_sequencer atps_check u_atps_check (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .tone_on        (rsp_chan.tone_on),
   .reload_value   (rsp_chan.reload_value),
   .compare_value  (rsp_chan.compare_value),
   .step_number    (rsp_chan.step_number),
   .pattern_number (rsp_chan.pattern_number)
);

`default_nettype wire
